@@ hdl/dns_pkg.sv @@
// shared types and constants of the decimal number scanner
// no dependencies

package dns_pkg;

  // largest digit count kept in a mantissa
  localparam int unsigned MaxDigits = 18;

  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned MantW  = 60;
  localparam int unsigned CountW = 5;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharPoint = 8'h2e;

  typedef enum logic [1:0] {
    ClsDigit,
    ClsMinus,
    ClsPoint,
    ClsOther
  } chr_class_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } dns_in_t;

  typedef struct packed {
    logic              negative;
    logic [MantW-1:0]  mantissa;
    logic [CountW-1:0] fraction_digits;
    logic              overflow;
  } dns_out_t;

  // classified character as it travels from front to back
  typedef struct packed {
    chr_class_e cls;
    logic [3:0] digit;
    logic       last;
  } dns_cls_t;

endpackage

@@ hdl/dns_front.sv @@
// front part: classifies each input character and queues it for the back part
// depends on dns_pkg

module dns_front import dns_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dns_in_t  in_data_i,
  output logic     q_valid_o,
  input  logic     q_pop_i,
  output dns_cls_t q_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  dns_cls_t            mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  dns_cls_t            cls_entry;
  logic                push, pop;

  // character classes
  always_comb begin
    cls_entry.last  = in_data_i.line_end;
    cls_entry.digit = 4'(in_data_i.char_code - CharZero);
    if (in_data_i.char_code >= CharZero && in_data_i.char_code <= CharNine) begin
      cls_entry.cls = ClsDigit;
    end else if (in_data_i.char_code == CharMinus) begin
      cls_entry.cls = ClsMinus;
    end else if (in_data_i.char_code == CharPoint) begin
      cls_entry.cls = ClsPoint;
    end else begin
      cls_entry.cls = ClsOther;
    end
  end

  assign in_ready_o = (cnt_q != CntW'(QueueDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls_entry;
    end
  end

endmodule

@@ hdl/dns_back.sv @@
// back part: token state, digit accumulation and the output register
// depends on dns_pkg

module dns_back import dns_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  output logic     q_pop_o,
  input  dns_cls_t q_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dns_out_t out_data_o
);

  logic              open_q, open_d;
  logic              pflag_q, pflag_d;
  logic              pit_q, pit_d;
  logic              sonly_q, sonly_d;
  logic              sign_q, sign_d;
  logic [MantW-1:0]  acc_q, acc_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] frac_q, frac_d;
  logic              long_q, long_d;
  logic              ovalid_q, ovalid_d;
  dns_out_t          odata_q, odata_d;

  logic              is_digit, is_minus, start, fire, emit;
  logic              e_sign, e_sonly, e_open, e_long;
  logic [MantW-1:0]  e_acc;
  logic [CountW-1:0] e_frac;

  // take an entry whenever the output slot is free or drains this cycle
  assign q_pop_o  = q_valid_i && (!ovalid_q || out_ready_i);
  assign fire     = q_pop_o;
  assign is_digit = (q_data_i.cls == ClsDigit);
  assign is_minus = (q_data_i.cls == ClsMinus);
  assign start    = is_digit || (!open_q && is_minus);

  always_comb begin
    open_d  = open_q;
    pflag_d = pflag_q;
    pit_d   = pit_q;
    sonly_d = sonly_q;
    sign_d  = sign_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    frac_d  = frac_q;
    long_d  = long_q;
    emit    = 1'b0;

    if (start) begin
      if (!open_q) begin
        open_d  = 1'b1;
        pit_d   = 1'b0;
        sign_d  = is_minus;
        sonly_d = is_minus;
        acc_d   = '0;
        cnt_d   = '0;
        frac_d  = '0;
        long_d  = 1'b0;
      end
      if (is_digit) begin
        sonly_d = 1'b0;
        if (cnt_d < CountW'(MaxDigits)) begin
          // times ten as two shifts and one add
          acc_d  = (acc_d << 3) + (acc_d << 1) + MantW'(q_data_i.digit);
          cnt_d  = cnt_d + 1'b1;
          frac_d = frac_d + CountW'(pit_d);
        end else begin
          long_d = 1'b1;
          cnt_d  = CountW'(MaxDigits + 1);
        end
      end
      emit = q_data_i.last;
    end else if (q_data_i.cls == ClsPoint && !pflag_q) begin
      pflag_d = 1'b1;
      if (open_q) begin
        pit_d   = 1'b1;
        sonly_d = 1'b0;
      end
    end else begin
      emit    = 1'b1;
      open_d  = 1'b0;
      pit_d   = 1'b0;
      sonly_d = 1'b0;
      sign_d  = 1'b0;
      acc_d   = '0;
      cnt_d   = '0;
      frac_d  = '0;
      long_d  = 1'b0;
      pflag_d = 1'b0;
    end

    // emitted token: updated state on a start, old state on a terminator
    e_open  = start ? open_d  : open_q;
    e_sonly = start ? sonly_d : sonly_q;
    e_sign  = start ? sign_d  : sign_q;
    e_acc   = start ? acc_d   : acc_q;
    e_frac  = start ? frac_d  : frac_q;
    e_long  = start ? long_d  : long_q;

    if (q_data_i.last) begin
      open_d  = 1'b0;
      pit_d   = 1'b0;
      sonly_d = 1'b0;
      sign_d  = 1'b0;
      acc_d   = '0;
      cnt_d   = '0;
      frac_d  = '0;
      long_d  = 1'b0;
      pflag_d = 1'b0;
    end

    odata_d.negative        = e_sign;
    odata_d.mantissa        = e_long ? '0 : e_acc;
    odata_d.fraction_digits = e_long ? '0 : e_frac;
    odata_d.overflow        = e_long;

    ovalid_d = ovalid_q && !out_ready_i;
    if (fire && emit && e_open && !e_sonly) begin
      ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      pflag_q  <= 1'b0;
      pit_q    <= 1'b0;
      sonly_q  <= 1'b0;
      sign_q   <= 1'b0;
      acc_q    <= '0;
      cnt_q    <= '0;
      frac_q   <= '0;
      long_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (fire) begin
        open_q  <= open_d;
        pflag_q <= pflag_d;
        pit_q   <= pit_d;
        sonly_q <= sonly_d;
        sign_q  <= sign_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        frac_q  <= frac_d;
        long_q  <= long_d;
      end
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      odata_q <= odata_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

@@ hdl/decimal_number_scanner.sv @@
// top level of the decimal number scanner: front classifier, queue and back
// depends on dns_pkg, dns_front, dns_back

// Scans a text line one character per beat and reports each signed decimal
// number as sign, mantissa of all its digits, count of digits after the
// point and an overflow flag for tokens longer than MaxDigits digits. The
// block takes one character per clock cycle while the output is not stalled.
// The character that closes a token passes through the front queue, and its
// result beat then through the back's output register, to the output.
// The rate is set by the back's token update, which folds one digit into the
// mantissa per cycle with a shift-and-add multiply by ten. The front queue
// holds two beats; while the output is stalled the back takes none of them,
// so input stays ready only until both queue entries are full, which while
// streaming is one more character after the stall begins.

module decimal_number_scanner import dns_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  // character beats
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dns_in_t  in_data_i,
  // number beats
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dns_out_t out_data_o
);

  // queue between front and back
  logic     q_valid;
  logic     q_pop;
  dns_cls_t q_data;

  // classify and queue
  dns_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_data_o   (q_data)
  );

  // token state and result register
  dns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
